// ===== rtl/core/fcbb_pkg.sv =====
package fcbb_pkg;

	localparam int PIX_W      = 32;
	localparam int POS_W      = 12;
	localparam int CNT_W      = 25;
	localparam int SIZE_W     = 13;
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(800);
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             first;
		logic             last;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} pix_s1_t;

	typedef struct packed {
		logic [PIX_W-1:0] background_pixel;
		logic [CNT_W-1:0] content_count;
		logic [POS_W-1:0] box_min_x;
		logic [POS_W-1:0] box_min_y;
		logic [POS_W-1:0] box_max_x;
		logic [POS_W-1:0] box_max_y;
	} box_t;

	// Last position on an axis: zero size acts as one, oversize saturates.
	function automatic logic [POS_W-1:0] last_pos(input logic [SIZE_W-1:0] size,
		input logic [SIZE_W-1:0] limit);
		logic [SIZE_W-1:0] eff;
		begin
			if (size == '0) begin
				eff = SIZE_W'(1);
			end else if (size > limit) begin
				eff = limit;
			end else begin
				eff = size;
			end
			last_pos = POS_W'(eff - SIZE_W'(1));
		end
	endfunction

endpackage

// ===== rtl/core/fcbb_if.sv =====
interface fcbb_pix_if;
	logic                          valid;
	logic                          ready;
	logic [fcbb_pkg::PIX_W-1:0]    pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

interface fcbb_box_if;
	logic                          valid;
	logic                          ready;
	logic [fcbb_pkg::PIX_W-1:0]    background_pixel;
	logic [fcbb_pkg::CNT_W-1:0]    content_count;
	logic [fcbb_pkg::POS_W-1:0]    box_min_x;
	logic [fcbb_pkg::POS_W-1:0]    box_min_y;
	logic [fcbb_pkg::POS_W-1:0]    box_max_x;
	logic [fcbb_pkg::POS_W-1:0]    box_max_y;

	modport source (output valid, output background_pixel, output content_count,
		output box_min_x, output box_min_y, output box_max_x, output box_max_y,
		input ready);
	modport sink (input valid, input background_pixel, input content_count,
		input box_min_x, input box_min_y, input box_max_x, input box_max_y,
		output ready);
endinterface

// ===== rtl/core/frame_content_bounding_box_core.sv =====
// Frame content bounding box.
// Pixels enter on the pixels channel, one word per pixel in raster order over
// a frame of frame_width by frame_height (register 0 and 1 of the write port).
// The first pixel of a frame is the background; the block counts the pixels
// that differ from it and tracks their bounding box. On the frame's last pixel
// one word leaves on the boxes channel: background, count and box (zero box
// when nothing differed).
// Throughput: one pixel per cycle, set by the single update stage, unless a
// last pixel waits there; it moves on into the output register once that is
// free, and the word is shown from then on until the receiver takes it.
// Receiver stall: the output register holds its word; the block keeps taking
// pixels until the next last pixel reaches the update stage, then input
// ready drops until the output word is taken.
// Reset: widths return to 800 by 480, the scan starts at a frame's first
// pixel, no word is held. A register write also restarts the scan.
module frame_content_bounding_box_core (
	input  logic                         clk,
	input  logic                         arst_n,
	fcbb_pix_if.sink                     pixels,
	fcbb_box_if.source                   boxes,
	input  logic                         wr_en,
	input  logic [0:0]                   wr_index,
	input  logic [fcbb_pkg::SIZE_W-1:0]  wr_data
);

	logic              valid_s1;
	fcbb_pkg::pix_s1_t word_s1;
	fcbb_pkg::box_t    result;
	fcbb_pkg::box_t    box_q;
	logic              out_valid_q;
	logic              out_free;
	logic              advance;
	logic              accept;

	assign out_free      = !out_valid_q || boxes.ready;
	assign advance       = valid_s1 && (!word_s1.last || out_free);
	assign pixels.ready  = !valid_s1 || advance;
	assign accept        = pixels.valid && pixels.ready;

	fcbb_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.accept   (accept),
		.pixel    (pixels.pixel_value),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	fcbb_stats u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.word_s1 (word_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && word_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (boxes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.last) begin
			box_q <= result;
		end
	end

	assign boxes.valid            = out_valid_q;
	assign boxes.background_pixel = box_q.background_pixel;
	assign boxes.content_count    = box_q.content_count;
	assign boxes.box_min_x        = box_q.box_min_x;
	assign boxes.box_min_y        = box_q.box_min_y;
	assign boxes.box_max_x        = box_q.box_max_x;
	assign boxes.box_max_y        = box_q.box_max_y;

endmodule

// ===== rtl/core/fcbb_scan.sv =====
module fcbb_scan (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [0:0]                      wr_index,
	input  logic [fcbb_pkg::SIZE_W-1:0]     wr_data,
	input  logic                            accept,
	input  logic [fcbb_pkg::PIX_W-1:0]      pixel,
	input  logic                            advance,
	output logic                            valid_s1,
	output fcbb_pkg::pix_s1_t               word_s1
);

	logic [fcbb_pkg::SIZE_W-1:0] width_q;
	logic [fcbb_pkg::SIZE_W-1:0] height_q;
	logic [fcbb_pkg::POS_W-1:0]  col_q;
	logic [fcbb_pkg::POS_W-1:0]  line_q;
	logic [fcbb_pkg::POS_W-1:0]  col_end;
	logic [fcbb_pkg::POS_W-1:0]  line_end;
	logic                        col_wrap;
	logic                        line_wrap;

	assign col_end   = fcbb_pkg::last_pos(width_q, fcbb_pkg::SIZE_W'(fcbb_pkg::MAX_WIDTH));
	assign line_end  = fcbb_pkg::last_pos(height_q, fcbb_pkg::SIZE_W'(fcbb_pkg::MAX_HEIGHT));
	assign col_wrap  = col_q >= col_end;
	assign line_wrap = line_q >= line_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= fcbb_pkg::WIDTH_RESET;
			height_q <= fcbb_pkg::HEIGHT_RESET;
			col_q    <= '0;
			line_q   <= '0;
		end else if (wr_en) begin
			// any register write restarts the frame
			unique case (fcbb_pkg::reg_index_t'(wr_index))
				fcbb_pkg::REG_FRAME_WIDTH:  width_q  <= wr_data;
				fcbb_pkg::REG_FRAME_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
			col_q  <= '0;
			line_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q  <= '0;
				line_q <= line_wrap ? '0 : line_q + fcbb_pkg::POS_W'(1);
			end else begin
				col_q <= col_q + fcbb_pkg::POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.pixel <= pixel;
			word_s1.first <= (col_q == '0) && (line_q == '0);
			word_s1.last  <= col_wrap && line_wrap;
			word_s1.x     <= col_q;
			word_s1.y     <= line_q;
		end
	end

endmodule

// ===== rtl/core/fcbb_stats.sv =====
module fcbb_stats (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  fcbb_pkg::pix_s1_t   word_s1,
	output fcbb_pkg::box_t      result
);

	logic [fcbb_pkg::PIX_W-1:0] bg_q,   bg_d;
	logic [fcbb_pkg::CNT_W-1:0] cnt_q,  cnt_d;
	logic [fcbb_pkg::POS_W-1:0] minx_q, minx_d;
	logic [fcbb_pkg::POS_W-1:0] miny_q, miny_d;
	logic [fcbb_pkg::POS_W-1:0] maxx_q, maxx_d;
	logic [fcbb_pkg::POS_W-1:0] maxy_q, maxy_d;

	always_comb begin
		bg_d   = bg_q;
		cnt_d  = cnt_q;
		minx_d = minx_q;
		miny_d = miny_q;
		maxx_d = maxx_q;
		maxy_d = maxy_q;
		if (word_s1.first) begin
			bg_d   = word_s1.pixel;
			cnt_d  = '0;
			minx_d = '1;
			miny_d = '1;
			maxx_d = '0;
			maxy_d = '0;
		end else if (word_s1.pixel != bg_q) begin
			if (cnt_q != '1) begin
				cnt_d = cnt_q + fcbb_pkg::CNT_W'(1);
			end
			if (word_s1.x < minx_q) minx_d = word_s1.x;
			if (word_s1.y < miny_q) miny_d = word_s1.y;
			if (word_s1.x > maxx_q) maxx_d = word_s1.x;
			if (word_s1.y > maxy_q) maxy_d = word_s1.y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q   <= '0;
			cnt_q  <= '0;
			minx_q <= '1;
			miny_q <= '1;
			maxx_q <= '0;
			maxy_q <= '0;
		end else if (advance) begin
			bg_q   <= bg_d;
			cnt_q  <= cnt_d;
			minx_q <= minx_d;
			miny_q <= miny_d;
			maxx_q <= maxx_d;
			maxy_q <= maxy_d;
		end
	end

	// an empty frame reports a zero box
	always_comb begin
		result.background_pixel = bg_d;
		result.content_count    = cnt_d;
		if (cnt_d != '0) begin
			result.box_min_x = minx_d;
			result.box_min_y = miny_d;
			result.box_max_x = maxx_d;
			result.box_max_y = maxy_d;
		end else begin
			result.box_min_x = '0;
			result.box_min_y = '0;
			result.box_max_x = '0;
			result.box_max_y = '0;
		end
	end

endmodule
